// File: src/uist_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uist_pkg
// shared types and constants for the unique id set table
// ----------------------------------------------------------------------------
package uist_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int SLOT_W   = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 64;
    localparam int MODE_W   = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_FIND   = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_REMOVE = 2'd2
    } t_mode;

    // search request travelling down the row of cells
    typedef struct packed {
        logic              vld;
        t_mode             mode;
        logic [VAL_W-1:0]  value;
        logic [SLOT_W-1:0] hw;       // mark at the time of the request
        logic              hit;
        logic [IDX_W-1:0]  hit_slot;
        logic              zf;       // empty slot seen
        logic [IDX_W-1:0]  zslot;
        logic [SLOT_W-1:0] last_nz;  // one above the highest occupied slot before the hit
    } t_probe;

    // write port shared by all cells
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] data;
    } t_wr;

endpackage

// File: src/unique_id_set_table_unit.sv
`timescale 1ns / 1ps
// path: a request passes 16 cells, one capture stage and one commit stage
// before its result is valid
// requests: one at a time, paced by the walk through the row of CAPACITY
// cells; the next request is taken once the previous one commits
// reset: synchronous, clears the mark, busy flag and all valid bits; slot
// contents are not cleared, slots at or above the mark are never compared
// ----------------------------------------------------------------------------
// unique_id_set_table_unit
// table of unique 64-bit ids searched by a request walking a row of slot cells
// ----------------------------------------------------------------------------
module unique_id_set_table_unit import uist_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [VAL_W-1:0] s_axis_tdata,   // [63:0] value
    input  logic [MODE_W-1:0] s_axis_tuser,  // [1:0] mode
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [7:0]       m_axis_tdata    // [4:0] slot, [5] status, [7:6] zero
);

    t_probe            w_probe [0:CAPACITY];
    t_probe            w_head;
    t_wr               w_wr;
    logic              w_accept;
    logic [SLOT_W-1:0] w_hw;
    logic [SLOT_W-1:0] w_slot;
    logic              w_status;
    logic [CAPACITY-1:0] w_cell_vld;

    assign w_accept = s_axis_tvalid && s_axis_tready;

    // fresh request enters the first cell with the current mark
    always_comb begin
        w_head.vld      = w_accept;
        w_head.mode     = t_mode'(s_axis_tuser);
        w_head.value    = s_axis_tdata;
        w_head.hw       = w_hw;
        w_head.hit      = 1'b0;
        w_head.hit_slot = '0;
        w_head.zf       = 1'b0;
        w_head.zslot    = '0;
        w_head.last_nz  = '0;
    end

    assign w_probe[0] = w_head;

    // row of slot cells, each hands the request on to the next every cycle
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        uist_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (IDX_W'(g)),
            .i_probe (w_probe[g]),
            .i_wr    (w_wr),
            .o_probe (w_probe[g+1])
        );
        assign w_cell_vld[g] = w_probe[g+1].vld;
    end

    // mark keeping, table update and result register
    uist_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_probe     (w_probe[CAPACITY]),
        .i_out_ready (m_axis_tready),
        .o_in_ready  (s_axis_tready),
        .o_hw        (w_hw),
        .o_wr        (w_wr),
        .o_out_vld   (m_axis_tvalid),
        .o_slot      (w_slot),
        .o_status    (w_status)
    );

    assign m_axis_tdata = {2'b00, w_status, w_slot};

`ifndef NO_ASSERTIONS
    // only one request is ever in the row
    a_one_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_cell_vld))
        else $error("more than one request in the cell row");

    // the mark never passes the capacity
    a_hw_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_hw <= SLOT_W'(CAPACITY))
        else $error("mark beyond capacity");

    // an accepted request blocks the input until it commits
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !s_axis_tready)
        else $error("input ready while a request is in flight");

    // a no-memory result never names a slot
    a_full_no_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && w_status) |-> (w_slot == SLOT_W'(CAPACITY)))
        else $error("no-memory result with a slot");
`endif

endmodule

// File: src/uist_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uist_cell
// one table slot: holds an entry and checks a passing request against it
// ----------------------------------------------------------------------------
module uist_cell import uist_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IDX_W-1:0] i_index,
    input  t_probe           i_probe,
    input  t_wr              i_wr,
    output t_probe           o_probe
);

    logic [VAL_W-1:0] r_entry;
    t_probe           r_probe;
    t_probe           n_probe;
    logic             w_below;
    logic             w_eq;
    logic             w_nz;

    always_comb begin
        n_probe = i_probe;
        w_below = {1'b0, i_index} < i_probe.hw;
        w_eq    = r_entry == i_probe.value;
        w_nz    = r_entry != '0;
        // slots at or above the mark are never looked at
        if (i_probe.vld && w_below && !i_probe.hit) begin
            if (w_eq) begin
                n_probe.hit      = 1'b1;
                n_probe.hit_slot = i_index;
            end else begin
                if (!w_nz && !i_probe.zf) begin
                    n_probe.zf    = 1'b1;
                    n_probe.zslot = i_index;
                end
                if (w_nz) begin
                    n_probe.last_nz = SLOT_W'(i_index) + SLOT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe.vld <= 1'b0;
        end else begin
            r_probe.vld <= n_probe.vld;
        end
        r_probe.mode     <= n_probe.mode;
        r_probe.value    <= n_probe.value;
        r_probe.hw       <= n_probe.hw;
        r_probe.hit      <= n_probe.hit;
        r_probe.hit_slot <= n_probe.hit_slot;
        r_probe.zf       <= n_probe.zf;
        r_probe.zslot    <= n_probe.zslot;
        r_probe.last_nz  <= n_probe.last_nz;
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en && (i_wr.idx == i_index)) begin
            r_entry <= i_wr.data;
        end
    end

    assign o_probe = r_probe;

endmodule

// File: src/uist_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uist_ctrl
// holds the mark, turns a finished search into a table update and a result
// ----------------------------------------------------------------------------
module uist_ctrl import uist_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  t_probe            i_probe,
    input  logic              i_out_ready,
    output logic              o_in_ready,
    output logic [SLOT_W-1:0] o_hw,
    output t_wr               o_wr,
    output logic              o_out_vld,
    output logic [SLOT_W-1:0] o_slot,
    output logic              o_status
);

    t_probe            r_fin;
    logic              r_busy;
    logic [SLOT_W-1:0] r_hw;
    logic              r_out_vld;
    logic [SLOT_W-1:0] r_slot;
    logic              r_status;

    logic              w_commit;
    logic [SLOT_W-1:0] w_place;
    logic [SLOT_W-1:0] n_hw;
    logic [SLOT_W-1:0] n_slot;
    logic              n_status;
    t_wr               n_wr;

    assign w_commit = r_fin.vld && (!r_out_vld || i_out_ready);

    always_comb begin
        n_hw     = r_hw;
        n_slot   = SLOT_W'(CAPACITY);
        n_status = 1'b0;
        n_wr.en   = 1'b0;
        n_wr.idx  = r_fin.hit_slot;
        n_wr.data = r_fin.value;
        w_place  = r_fin.hit ? {1'b0, r_fin.hit_slot} :
                   r_fin.zf  ? {1'b0, r_fin.zslot} : r_hw;
        unique case (r_fin.mode)
            MODE_FIND: begin
                if (r_fin.hit) begin
                    n_slot = {1'b0, r_fin.hit_slot};
                end
            end
            MODE_INSERT: begin
                if (w_place < SLOT_W'(CAPACITY)) begin
                    n_wr.en  = 1'b1;
                    n_wr.idx = w_place[IDX_W-1:0];
                    n_slot   = w_place;
                    if (w_place == r_hw) begin
                        n_hw = r_hw + SLOT_W'(1);
                    end
                end else begin
                    n_status = 1'b1;
                end
            end
            MODE_REMOVE: begin
                if (r_fin.hit) begin
                    n_wr.en   = 1'b1;
                    n_wr.data = '0;
                    n_slot    = {1'b0, r_fin.hit_slot};
                    // top slot freed: drop past the empty run beneath it
                    if ({1'b0, r_fin.hit_slot} + SLOT_W'(1) == r_hw) begin
                        n_hw = r_fin.last_nz;
                    end
                end
            end
            default: begin
                n_slot = SLOT_W'(CAPACITY);
            end
        endcase
        n_wr.en = n_wr.en && w_commit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin.vld <= 1'b0;
            r_busy    <= 1'b0;
            r_hw      <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_accept) begin
                r_busy <= 1'b1;
            end else if (w_commit) begin
                r_busy <= 1'b0;
            end
            if (w_commit) begin
                r_fin.vld <= 1'b0;
                r_hw      <= n_hw;
                r_out_vld <= 1'b1;
            end else begin
                if (i_probe.vld) begin
                    r_fin.vld <= 1'b1;
                end
                if (r_out_vld && i_out_ready) begin
                    r_out_vld <= 1'b0;
                end
            end
        end
        if (!r_fin.vld && i_probe.vld) begin
            r_fin.mode     <= i_probe.mode;
            r_fin.value    <= i_probe.value;
            r_fin.hw       <= i_probe.hw;
            r_fin.hit      <= i_probe.hit;
            r_fin.hit_slot <= i_probe.hit_slot;
            r_fin.zf       <= i_probe.zf;
            r_fin.zslot    <= i_probe.zslot;
            r_fin.last_nz  <= i_probe.last_nz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_slot   <= n_slot;
            r_status <= n_status;
        end
    end

    assign o_in_ready = !r_busy;
    assign o_hw       = r_hw;
    assign o_wr       = n_wr;
    assign o_out_vld  = r_out_vld;
    assign o_slot     = r_slot;
    assign o_status   = r_status;

endmodule

// File: tb/tb_unique_id_set_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_unique_id_set_table_unit
// self-checking bench for the unique id set table: find, insert and remove
// requests go in over the input stream, every result is compared with a
// shadow copy of the table kept in the bench
// ----------------------------------------------------------------------------
module tb_unique_id_set_table_unit;
    import uist_pkg::*;

    // codes that the package does not name
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;      // unused operation
    localparam logic              ST_OK      = 1'b0;
    localparam logic              ST_NO_MEM  = 1'b1;
    localparam logic [SLOT_W-1:0] SLOT_NONE  = SLOT_W'(CAPACITY);
    localparam logic [VAL_W-1:0]  ALL_ONES   = {VAL_W{1'b1}};

    localparam int RANDOM_REQUESTS = 1920;
    localparam int POOL_SIZE       = 24;
    localparam int POOL_W          = $clog2(POOL_SIZE);
    localparam int LONG_HOLD       = 400;   // cycles the result side refuses
    localparam int DRAIN_CYCLES    = 40;    // idle margin after the last expected result

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              status;
    } t_answer;

    // one row of the directed plan; typed rows carry a hand-written answer
    typedef struct {
        logic [MODE_W-1:0] op;
        logic [VAL_W-1:0]  id;
        bit                typed;
        t_answer           ans;
    } t_row;

    logic             i_clk;
    logic             i_rst_n       = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [VAL_W-1:0] s_axis_tdata  = '0;    // [63:0] value
    logic [MODE_W-1:0] s_axis_tuser = '0;    // [1:0] mode
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [7:0]       m_axis_tdata;          // [4:0] slot, [5] status, [7:6] zero

    // shadow of the table: slot contents and the high-water mark
    logic [VAL_W-1:0]  shadow_ids [CAPACITY];
    logic [SLOT_W-1:0] shadow_mark;

    t_answer answers_due [$];
    t_row    directed    [$];
    logic [VAL_W-1:0] id_pool [POOL_SIZE];

    int mismatches   = 0;
    int results_seen = 0;
    int sent         = 0;
    int n_find = 0, n_insert = 0, n_refused = 0, n_remove = 0, n_spare = 0;
    bit long_hold_done = 1'b0;

    unique_id_set_table_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // generous cap well above the slowest legal run
    initial begin
        #30_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // mostly back to back, some short pauses, the odd long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 60);
    endfunction

    // apply one request to the shadow table and return what the block should say
    function automatic t_answer apply_request(logic [MODE_W-1:0] op, logic [VAL_W-1:0] id);
        t_answer ans;
        int      hit;
        int      first_free;
        int      place;
        ans.slot   = SLOT_NONE;
        ans.status = ST_OK;
        hit        = CAPACITY;
        first_free = int'(shadow_mark);
        // only slots below the mark take part in the scan
        for (int i = 0; i < int'(shadow_mark); i++) begin
            if (hit == CAPACITY && shadow_ids[IDX_W'(i)] == id)
                hit = i;
            if (first_free == int'(shadow_mark) && shadow_ids[IDX_W'(i)] == '0)
                first_free = i;
        end
        case (op)
            MODE_FIND: begin
                n_find++;
                ans.slot = SLOT_W'(hit);
            end
            MODE_INSERT: begin
                n_insert++;
                // a match wins even over an earlier free slot
                place = (hit < CAPACITY) ? hit : first_free;
                if (place < CAPACITY) begin
                    shadow_ids[IDX_W'(place)] = id;
                    if (place == int'(shadow_mark))
                        shadow_mark = shadow_mark + SLOT_W'(1);
                    ans.slot = SLOT_W'(place);
                end else begin
                    n_refused++;
                    ans.status = ST_NO_MEM;
                end
            end
            MODE_REMOVE: begin
                n_remove++;
                if (hit < CAPACITY) begin
                    shadow_ids[IDX_W'(hit)] = '0;
                    // top slot cleared: mark drops past any empty slots beneath
                    if (hit + 1 == int'(shadow_mark)) begin
                        shadow_mark = SLOT_W'(hit);
                        while (shadow_mark != '0 &&
                               shadow_ids[IDX_W'(shadow_mark - SLOT_W'(1))] == '0)
                            shadow_mark = shadow_mark - SLOT_W'(1);
                    end
                    ans.slot = SLOT_W'(hit);
                end
            end
            default: n_spare++;
        endcase
        return ans;
    endfunction

    function automatic void add_row(logic [MODE_W-1:0] op, logic [VAL_W-1:0] id, bit typed,
                                    logic [SLOT_W-1:0] slot, logic status);
        t_row row;
        row.op         = op;
        row.id         = id;
        row.typed      = typed;
        row.ans.slot   = slot;
        row.ans.status = status;
        directed.push_back(row);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        if (mismatches <= 20)
            $display("mismatch at %0t ns: %s, got %0h, expected %0h", $realtime, what, got, want);
    endtask

    // present one request, hold it until taken, then log the expected answer
    task automatic offer(input logic [MODE_W-1:0] op, input logic [VAL_W-1:0] id,
                         input bit typed, input t_answer typed_ans, input bit calm);
        t_answer     ans;
        int unsigned gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= id;
        s_axis_tuser  <= op;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        ans = apply_request(op, id);
        answers_due.push_back(typed ? typed_ans : ans);
        sent++;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // result side: random back-pressure plus one long hold-off
    initial begin : result_side
        int unsigned hold;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (!long_hold_done && results_seen >= 300) begin
                // block holds its result and has to refuse new requests
                long_hold_done = 1'b1;
                hold = LONG_HOLD;
            end
            if (hold > 0) begin
                m_axis_tready <= 1'b0;
                hold--;
            end else begin
                m_axis_tready <= 1'b1;
                hold = (((results_seen / 200) % 4) == 1) ? 0 : pick_gap();
            end
        end
    end

    // compare each result with the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_answer want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (answers_due.size() == 0) begin
                report_mismatch("result with nothing expected", 64'(m_axis_tdata), 64'(0));
            end else begin
                want = answers_due.pop_front();
                if (m_axis_tdata[4:0] !== want.slot)
                    report_mismatch("slot", 64'(m_axis_tdata[4:0]), 64'(want.slot));
                if (m_axis_tdata[5] !== want.status)
                    report_mismatch("status", 64'(m_axis_tdata[5]), 64'(want.status));
                if (m_axis_tdata[7:6] !== 2'b00)
                    report_mismatch("padding", 64'(m_axis_tdata[7:6]), 64'(0));
            end
        end
    end

    initial begin : request_side
        t_answer          no_ans;
        t_row             row;
        logic [MODE_W-1:0] op;
        logic [VAL_W-1:0] id;
        int unsigned      r;
        bit               filling;

        no_ans = '0;
        for (int i = 0; i < CAPACITY; i++)
            shadow_ids[IDX_W'(i)] = '0;
        shadow_mark = '0;

        // small pool so that hits, refills and a full table are common
        id_pool[0] = '0;
        for (int i = 1; i <= 8; i++)
            id_pool[POOL_W'(i)] = VAL_W'(i);
        for (int i = 9; i < POOL_SIZE; i++)
            id_pool[POOL_W'(i)] = {$urandom, $urandom};

        // empty table, spare mode, zero and all-ones ids
        add_row(MODE_FIND,   64'd5,    1'b1, SLOT_NONE,  ST_OK);
        add_row(MODE_REMOVE, 64'd5,    1'b1, SLOT_NONE,  ST_OK);
        add_row(MODE_SPARE,  ALL_ONES, 1'b1, SLOT_NONE,  ST_OK);
        add_row(MODE_INSERT, 64'd0,    1'b1, 5'd0,       ST_OK);
        // the zero id leaves its slot looking empty, so it is taken again
        add_row(MODE_INSERT, ALL_ONES, 1'b1, 5'd0,       ST_OK);
        add_row(MODE_FIND,   ALL_ONES, 1'b1, 5'd0,       ST_OK);
        add_row(MODE_REMOVE, 64'd0,    1'b1, SLOT_NONE,  ST_OK);
        add_row(MODE_INSERT, 64'd5,    1'b1, 5'd1,       ST_OK);
        add_row(MODE_REMOVE, ALL_ONES, 1'b1, 5'd0,       ST_OK);
        // top slot cleared, mark falls through the empty slot below it
        add_row(MODE_REMOVE, 64'd5,    1'b1, 5'd1,       ST_OK);
        add_row(MODE_FIND,   64'd0,    1'b1, SLOT_NONE,  ST_OK);
        // fill every slot, then overflow
        for (int i = 1; i <= CAPACITY; i++)
            add_row(MODE_INSERT, {4'(i), 60'h1}, 1'b1, SLOT_W'(i - 1), ST_OK);
        add_row(MODE_INSERT, 64'hdead_beef_0000_0001, 1'b1, SLOT_NONE, ST_NO_MEM);
        add_row(MODE_INSERT, {4'd5, 60'h1},           1'b1, 5'd4,      ST_OK);
        // hole below the top, then the top goes and the mark walks down
        add_row(MODE_REMOVE, {4'd14, 60'h1}, 1'b0, '0, ST_OK);
        add_row(MODE_REMOVE, {4'd0, 60'h1},  1'b0, '0, ST_OK);
        add_row(MODE_REMOVE, {4'd15, 60'h1}, 1'b0, '0, ST_OK);
        add_row(MODE_INSERT, 64'd0,          1'b0, '0, ST_OK);
        add_row(MODE_REMOVE, 64'd0,          1'b0, '0, ST_OK);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k]) begin
            row = directed[k];
            offer(row.op, row.id, row.typed, row.ans, 1'b0);
        end

        // random traffic, alternating between filling and draining the table
        for (int k = 0; k < RANDOM_REQUESTS; k++) begin
            filling = ((k / 120) % 2) == 0;
            r = $urandom_range(0, 99);
            if (r < 3)
                op = MODE_SPARE;
            else if (r < (filling ? 58 : 28))
                op = MODE_INSERT;
            else if (r < 78)
                op = MODE_REMOVE;
            else
                op = MODE_FIND;
            id = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
                                             : id_pool[POOL_W'($urandom_range(0, POOL_SIZE - 1))];
            offer(op, id, 1'b0, no_ans, ((k / 200) % 4) == 3);
        end
        s_axis_tvalid <= 1'b0;

        while (answers_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d requests: %0d find, %0d insert (%0d refused, table full),",
                 sent, n_find, n_insert, n_refused);
        $display("%0d remove, %0d spare-mode; %0d results checked, %0d mismatches",
                 n_remove, n_spare, results_seen, mismatches);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: filelist.f
src/uist_pkg.sv
src/uist_cell.sv
src/uist_ctrl.sv
src/unique_id_set_table_unit.sv
tb/tb_unique_id_set_table_unit.sv
